// ===== hdl/ffha_pkg.sv =====
// Shared types, codes and constants of the first-fit heap allocator.
package ffha_pkg;

	// Default heap size in words
	localparam int unsigned HEAP_WORDS_DEF = 4096;
	// Slack register value after reset
	localparam logic [7:0] SLACK_RESET = 8'd8;
	// Byte-to-word rounding addend
	localparam int unsigned BYTES_ROUND = 3;

	// Request actions
	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_RESIZE = 2'd2;
	// Unused encoding, answered as a bad argument
	localparam logic [1:0] ACT_RSVD   = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_ROOM = 2'd1;
	localparam logic [1:0] ST_BAD_ARG = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [14:0] byte_length;
		logic [12:0] payload_address;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] result_address;
		logic [11:0] block_words;
	} out_beat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_V_RD, S_V_EV, S_V_CHK,
		S_G_FIRST, S_G_CHK, S_G_EV, S_G_TEST, S_G_FIT, S_G_WH,
		S_A_CHK, S_A_EV, S_R_CHK, S_R_EV, S_R_END, S_A_SPL, S_M_FREE, S_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_WALK, OP_HDR, OP_GROW_START, OP_ACCUM, OP_RESTART,
		OP_RUN_START, OP_SET_GOT_LEN, OP_WR_GROW_SPLIT, OP_WR_GROW_HDR,
		OP_WR_ALLOC_HDR, OP_WR_ALLOC_SPLIT, OP_WR_NEG_P, OP_RES
	} dp_op_t;

	typedef enum logic [1:0] {
		RS_NONE, RS_BASE, RS_P
	} rsel_t;

	// Command from controller to datapath
	typedef struct packed {
		dp_op_t     op;
		logic [1:0] st;
		rsel_t      rsel;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [1:0] act;
		logic       bytes_zero;
		logic       addr_zero;
		logic       p_in;
		logic       cur_in;
		logic       cur_eq_p;
		logic       cur_gt_p;
		logic       rd_neg;
		logic       hdr_neg;
		logic       len_ge_w;
		logic       rest_ge2;
		logic       grow_split;
	} dp_stat_t;

endpackage

// ===== hdl/ffha_dp.sv =====
// Datapath of the allocator: heap memory, walk pointer, length accumulators, result register.
module ffha_dp #(
	parameter int unsigned HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ffha_pkg::in_beat_t req,
	input  ffha_pkg::dp_cmd_t  cmd,
	input  logic [7:0]         slack,
	output ffha_pkg::dp_stat_t stat,
	output ffha_pkg::out_beat_t res
);
	localparam int unsigned AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
	localparam int unsigned LW = (AW + 2 > 15) ? AW + 2 : 15;
	localparam logic [LW-1:0] N_L = LW'(HEAP_WORDS);
	localparam logic [31:0] W0_INIT = 32'(-(HEAP_WORDS - 1));

	logic [31:0]   mem [HEAP_WORDS];
	logic [31:0]   mem_rd_q;
	logic          rd_zero_q;
	logic          w0_valid_q;

	logic [1:0]    act_q;
	logic          bytes_zero_q;
	logic          addr_zero_q;
	logic [LW-1:0] p_q;
	logic [LW-1:0] w_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] base_q;
	logic [LW-1:0] got_q;
	logic [31:0]   hdr_q;
	ffha_pkg::out_beat_t res_q;

	logic [31:0]   rdata;
	logic [31:0]   rd_abs;
	logic [LW-1:0] mag;
	logic [LW-1:0] step;
	logic [15:0]   bytes_rnd;
	logic          we;
	logic [LW-1:0] wa;
	logic [31:0]   wd;
	logic [LW-1:0] hdr_mag;

	// Read data with the reset header of word 0
	assign rdata  = (rd_zero_q && !w0_valid_q) ? W0_INIT : mem_rd_q;
	assign rd_abs = rdata[31] ? (32'd0 - rdata) : rdata;
	assign mag    = rd_abs[LW-1:0];
	assign step   = mag + LW'(1);
	assign hdr_mag = hdr_q[LW-1:0];
	assign bytes_rnd = 16'(req.byte_length) + 16'(ffha_pkg::BYTES_ROUND);

	// Status toward the controller
	always_comb begin
		stat.act        = act_q;
		stat.bytes_zero = bytes_zero_q;
		stat.addr_zero  = addr_zero_q;
		stat.p_in       = !addr_zero_q && (p_q < N_L);
		stat.cur_in     = cur_q < N_L;
		stat.cur_eq_p   = cur_q == p_q;
		stat.cur_gt_p   = cur_q > p_q;
		stat.rd_neg     = rdata[31];
		stat.hdr_neg    = hdr_q[31];
		stat.len_ge_w   = len_q >= w_q;
		stat.rest_ge2   = len_q >= w_q + LW'(2);
		stat.grow_split = (len_q > w_q + LW'(slack)) && (len_q >= w_q + LW'(2));
	end

	// Memory write port
	always_comb begin
		we = 1'b0;
		wa = p_q;
		wd = 32'd0;
		case (cmd.op)
			ffha_pkg::OP_WR_GROW_SPLIT: begin
				we = 1'b1;
				wa = p_q + LW'(1) + w_q;
				wd = 32'd0 - 32'(len_q - w_q - LW'(1));
			end
			ffha_pkg::OP_WR_GROW_HDR: begin
				we = 1'b1;
				wa = p_q;
				wd = 32'(got_q);
			end
			ffha_pkg::OP_WR_ALLOC_HDR: begin
				we = 1'b1;
				wa = base_q;
				wd = stat.rest_ge2 ? 32'(w_q) : 32'(len_q);
			end
			ffha_pkg::OP_WR_ALLOC_SPLIT: begin
				we = 1'b1;
				wa = base_q + LW'(1) + w_q;
				wd = 32'd0 - 32'(len_q - w_q - LW'(1));
			end
			ffha_pkg::OP_WR_NEG_P: begin
				we = 1'b1;
				wa = p_q;
				wd = 32'd0 - hdr_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Heap memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa[AW-1:0]] <= wd;
		end
		mem_rd_q <= mem[cur_q[AW-1:0]];
	end

	// Word 0 holds its reset header until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_valid_q <= 1'b0;
			rd_zero_q  <= 1'b0;
		end else begin
			rd_zero_q <= cur_q[AW-1:0] == '0;
			if (we && wa[AW-1:0] == '0) begin
				w0_valid_q <= 1'b1;
			end
		end
	end

	// Walk registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			ffha_pkg::OP_LOAD: begin
				act_q        <= req.action;
				bytes_zero_q <= req.byte_length == '0;
				addr_zero_q  <= req.payload_address == '0;
				p_q          <= LW'(req.payload_address) - LW'(1);
				w_q          <= LW'(bytes_rnd[15:2]);
				cur_q        <= '0;
				got_q        <= '0;
			end
			ffha_pkg::OP_WALK: begin
				cur_q <= cur_q + step;
			end
			ffha_pkg::OP_HDR: begin
				hdr_q <= rdata;
			end
			ffha_pkg::OP_GROW_START: begin
				len_q <= hdr_mag;
				cur_q <= p_q + LW'(1) + hdr_mag;
			end
			ffha_pkg::OP_ACCUM: begin
				len_q <= len_q + step;
				cur_q <= cur_q + step;
			end
			ffha_pkg::OP_RESTART: begin
				cur_q <= '0;
			end
			ffha_pkg::OP_RUN_START: begin
				base_q <= cur_q;
				len_q  <= mag;
				cur_q  <= cur_q + step;
			end
			ffha_pkg::OP_SET_GOT_LEN: begin
				got_q <= len_q;
			end
			ffha_pkg::OP_WR_GROW_SPLIT: begin
				got_q <= w_q;
			end
			ffha_pkg::OP_WR_ALLOC_HDR: begin
				got_q <= stat.rest_ge2 ? w_q : len_q;
			end
			ffha_pkg::OP_RES: begin
				res_q.status <= cmd.st;
				case (cmd.rsel)
					ffha_pkg::RS_BASE: begin
						res_q.result_address <= 13'(base_q + LW'(1));
						res_q.block_words    <= got_q[11:0];
					end
					ffha_pkg::RS_P: begin
						res_q.result_address <= 13'(p_q + LW'(1));
						res_q.block_words    <= got_q[11:0];
					end
					default: begin
						res_q.result_address <= '0;
						res_q.block_words    <= '0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

// ===== hdl/ffha_ctrl.sv =====
// Controller state machine of the allocator: sequences validation, grow, and first-fit walks.
module ffha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  ffha_pkg::dp_stat_t stat,
	output ffha_pkg::dp_cmd_t  cmd
);
	ffha_pkg::state_t state_q, state_d;
	logic [1:0]       st_q, st_d;
	ffha_pkg::rsel_t  rs_q, rs_d;
	logic             out_vld_q;
	logic             move;
	logic             can_emit;
	logic [1:0]       bad_code;

	assign move     = stat.act == ffha_pkg::ACT_RESIZE && !stat.addr_zero;
	assign can_emit = !out_vld_q || !out_stall;
	assign bad_code = (stat.act == ffha_pkg::ACT_FREE) ? ffha_pkg::ST_IGNORED
	                                                   : ffha_pkg::ST_BAD_ARG;
	assign in_stall  = state_q != ffha_pkg::S_IDLE;
	assign out_valid = out_vld_q;

	// Next state
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		rs_d    = rs_q;
		case (state_q)
			ffha_pkg::S_IDLE: begin
				if (in_valid) state_d = ffha_pkg::S_DECODE;
			end
			ffha_pkg::S_DECODE: begin
				state_d = ffha_pkg::S_FIN;
				rs_d    = ffha_pkg::RS_NONE;
				if (stat.act == ffha_pkg::ACT_FREE) begin
					if (stat.p_in) state_d = ffha_pkg::S_V_RD;
					else st_d = ffha_pkg::ST_IGNORED;
				end else if (stat.act == ffha_pkg::ACT_RSVD || stat.bytes_zero) begin
					st_d = ffha_pkg::ST_BAD_ARG;
				end else if (move) begin
					if (stat.p_in) state_d = ffha_pkg::S_V_RD;
					else st_d = ffha_pkg::ST_BAD_ARG;
				end else begin
					state_d = ffha_pkg::S_A_CHK;
				end
			end
			ffha_pkg::S_V_RD: state_d = ffha_pkg::S_V_EV;
			ffha_pkg::S_V_EV: begin
				if (stat.cur_eq_p) begin
					state_d = ffha_pkg::S_V_CHK;
				end else if (stat.cur_gt_p) begin
					state_d = ffha_pkg::S_FIN;
					st_d    = bad_code;
					rs_d    = ffha_pkg::RS_NONE;
				end else begin
					state_d = ffha_pkg::S_V_RD;
				end
			end
			ffha_pkg::S_V_CHK: begin
				if (stat.hdr_neg) begin
					state_d = ffha_pkg::S_FIN;
					st_d    = bad_code;
					rs_d    = ffha_pkg::RS_NONE;
				end else if (stat.act == ffha_pkg::ACT_FREE) begin
					state_d = ffha_pkg::S_FIN;
					st_d    = ffha_pkg::ST_OK;
					rs_d    = ffha_pkg::RS_NONE;
				end else begin
					state_d = ffha_pkg::S_G_FIRST;
				end
			end
			ffha_pkg::S_G_FIRST: begin
				if (stat.len_ge_w) begin
					state_d = ffha_pkg::S_FIN;
					st_d    = ffha_pkg::ST_OK;
					rs_d    = ffha_pkg::RS_P;
				end else begin
					state_d = ffha_pkg::S_G_CHK;
				end
			end
			ffha_pkg::S_G_CHK: begin
				state_d = stat.cur_in ? ffha_pkg::S_G_EV : ffha_pkg::S_A_CHK;
			end
			ffha_pkg::S_G_EV: begin
				state_d = stat.rd_neg ? ffha_pkg::S_G_TEST : ffha_pkg::S_A_CHK;
			end
			ffha_pkg::S_G_TEST: begin
				state_d = stat.len_ge_w ? ffha_pkg::S_G_FIT : ffha_pkg::S_G_CHK;
			end
			ffha_pkg::S_G_FIT: state_d = ffha_pkg::S_G_WH;
			ffha_pkg::S_G_WH: begin
				state_d = ffha_pkg::S_FIN;
				st_d    = ffha_pkg::ST_OK;
				rs_d    = ffha_pkg::RS_P;
			end
			ffha_pkg::S_A_CHK: begin
				if (stat.cur_in) begin
					state_d = ffha_pkg::S_A_EV;
				end else begin
					state_d = ffha_pkg::S_FIN;
					st_d    = ffha_pkg::ST_NO_ROOM;
					rs_d    = ffha_pkg::RS_NONE;
				end
			end
			ffha_pkg::S_A_EV: begin
				state_d = stat.rd_neg ? ffha_pkg::S_R_CHK : ffha_pkg::S_A_CHK;
			end
			ffha_pkg::S_R_CHK: begin
				state_d = stat.cur_in ? ffha_pkg::S_R_EV : ffha_pkg::S_R_END;
			end
			ffha_pkg::S_R_EV: begin
				state_d = stat.rd_neg ? ffha_pkg::S_R_CHK : ffha_pkg::S_R_END;
			end
			ffha_pkg::S_R_END: begin
				if (!stat.len_ge_w) begin
					state_d = ffha_pkg::S_A_CHK;
				end else if (stat.rest_ge2) begin
					state_d = ffha_pkg::S_A_SPL;
				end else if (move) begin
					state_d = ffha_pkg::S_M_FREE;
				end else begin
					state_d = ffha_pkg::S_FIN;
					st_d    = ffha_pkg::ST_OK;
					rs_d    = ffha_pkg::RS_BASE;
				end
			end
			ffha_pkg::S_A_SPL: begin
				if (move) begin
					state_d = ffha_pkg::S_M_FREE;
				end else begin
					state_d = ffha_pkg::S_FIN;
					st_d    = ffha_pkg::ST_OK;
					rs_d    = ffha_pkg::RS_BASE;
				end
			end
			ffha_pkg::S_M_FREE: begin
				state_d = ffha_pkg::S_FIN;
				st_d    = ffha_pkg::ST_OK;
				rs_d    = ffha_pkg::RS_BASE;
			end
			ffha_pkg::S_FIN: begin
				if (can_emit) state_d = ffha_pkg::S_IDLE;
			end
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd.op   = ffha_pkg::OP_NONE;
		cmd.st   = st_q;
		cmd.rsel = rs_q;
		case (state_q)
			ffha_pkg::S_IDLE: begin
				if (in_valid) cmd.op = ffha_pkg::OP_LOAD;
			end
			ffha_pkg::S_V_EV: begin
				if (stat.cur_eq_p) cmd.op = ffha_pkg::OP_HDR;
				else if (!stat.cur_gt_p) cmd.op = ffha_pkg::OP_WALK;
			end
			ffha_pkg::S_V_CHK: begin
				if (!stat.hdr_neg) begin
					cmd.op = (stat.act == ffha_pkg::ACT_FREE) ? ffha_pkg::OP_WR_NEG_P
					                                          : ffha_pkg::OP_GROW_START;
				end
			end
			ffha_pkg::S_G_FIRST: begin
				if (stat.len_ge_w) cmd.op = ffha_pkg::OP_SET_GOT_LEN;
			end
			ffha_pkg::S_G_CHK: begin
				if (!stat.cur_in) cmd.op = ffha_pkg::OP_RESTART;
			end
			ffha_pkg::S_G_EV: begin
				cmd.op = stat.rd_neg ? ffha_pkg::OP_ACCUM : ffha_pkg::OP_RESTART;
			end
			ffha_pkg::S_G_FIT: begin
				cmd.op = stat.grow_split ? ffha_pkg::OP_WR_GROW_SPLIT
				                         : ffha_pkg::OP_SET_GOT_LEN;
			end
			ffha_pkg::S_G_WH:   cmd.op = ffha_pkg::OP_WR_GROW_HDR;
			ffha_pkg::S_A_EV: begin
				cmd.op = stat.rd_neg ? ffha_pkg::OP_RUN_START : ffha_pkg::OP_WALK;
			end
			ffha_pkg::S_R_EV: begin
				if (stat.rd_neg) cmd.op = ffha_pkg::OP_ACCUM;
			end
			ffha_pkg::S_R_END: begin
				if (stat.len_ge_w) cmd.op = ffha_pkg::OP_WR_ALLOC_HDR;
			end
			ffha_pkg::S_A_SPL:  cmd.op = ffha_pkg::OP_WR_ALLOC_SPLIT;
			ffha_pkg::S_M_FREE: cmd.op = ffha_pkg::OP_WR_NEG_P;
			ffha_pkg::S_FIN: begin
				if (can_emit) cmd.op = ffha_pkg::OP_RES;
			end
			default: cmd.op = ffha_pkg::OP_NONE;
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ffha_pkg::S_IDLE;
			st_q      <= ffha_pkg::ST_OK;
			rs_q      <= ffha_pkg::RS_NONE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			rs_q    <= rs_d;
			if (cmd.op == ffha_pkg::OP_RES) out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/first_fit_heap_allocator_core.sv =====
// Top level of the first-fit heap allocator: configuration port, controller and datapath.
// One request is in work at a time. A request walks the heap headers from word 0,
// reading each header through the single read port of the heap memory and then
// evaluating it, besides decode, header writes and result hand-off; a request that
// meets no headers (bad argument) goes straight from decode to the result.
// The heap needs no clearing pass: word 0 reads as one free block over the whole
// heap until first written. A finished result waits in an output register while
// the next request is taken. split_slack_words sits at byte address 0.
module first_fit_heap_allocator_core #(
	parameter int unsigned HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ffha_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ffha_pkg::out_beat_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	logic [7:0]         slack_q;
	ffha_pkg::dp_cmd_t  cmd;
	ffha_pkg::dp_stat_t stat;

	// Slack register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slack_q <= ffha_pkg::SLACK_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			slack_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(slack_q);

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffha_dp #(
		.HEAP_WORDS (HEAP_WORDS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (in_data),
		.cmd    (cmd),
		.slack  (slack_q),
		.stat   (stat),
		.res    (out_data)
	);

endmodule
